>>> sv/touch_event_to_screen_point_unit_macros.svh
// ----------------------------------------------------------------------------
// Touch event to screen point: assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOUCH_EVENT_TO_SCREEN_POINT_UNIT_MACROS_SVH
`define TOUCH_EVENT_TO_SCREEN_POINT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TESP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define TESP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TESP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TESP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> sv/tesp_pkg.sv
// ----------------------------------------------------------------------------
// Touch event to screen point: shared package
// Field widths and the command and status bundles of the axis scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package tesp_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   localparam int RAW_BITS       = 32;
   localparam int SIZE_BITS      = 13;
   localparam int DIFF_BITS      = RAW_BITS + 1;
   localparam int PROD_BITS      = DIFF_BITS + SIZE_BITS;
   localparam int QUO_BITS       = 13;
   localparam int TYPE_BITS      = 5;
   localparam int CODE_BITS      = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int ROT_BITS       = 2;

   typedef struct packed {
      logic                        start;
      logic signed [RAW_BITS-1:0]  raw;
      logic signed [RAW_BITS-1:0]  lo;
      logic signed [RAW_BITS-1:0]  hi;
      logic        [SIZE_BITS-1:0] size;
   } scl_cmd_type;

   typedef struct packed {
      logic                       done;
      logic        [QUO_BITS-1:0] result;
   } scl_rsp_type;

endpackage

`default_nettype wire

>>> sv/tesp_channels.sv
// ----------------------------------------------------------------------------
// Touch event to screen point: channel interfaces
// Valid/ready interfaces for the event input and the screen point output.
// ----------------------------------------------------------------------------
`default_nettype none

interface tesp_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [tesp_pkg::TYPE_BITS-1:0]  event_type;
   logic        [tesp_pkg::CODE_BITS-1:0]  event_code;
   logic signed [tesp_pkg::RAW_BITS-1:0]   event_value;

   modport source (output valid, event_type, event_code, event_value, input ready);
   modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface tesp_rsp_if #(
   parameter int COORD_BITS = tesp_pkg::COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  pressed;
   logic                  point_valid;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;

   modport source (output valid, pressed, point_valid, point_x, point_y, input ready);
   modport sink   (input valid, pressed, point_valid, point_x, point_y, output ready);
endinterface

`default_nettype wire

>>> sv/tesp_axis_scaler.sv
// ----------------------------------------------------------------------------
// Touch event to screen point: axis scaler
// Clamps a raw coordinate and scales it to the panel size with a bit-serial
// multiply and a bit-serial restoring division rounded to nearest.
// ----------------------------------------------------------------------------
`default_nettype none
`include "touch_event_to_screen_point_unit_macros.svh"

module tesp_axis_scaler (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tesp_pkg::scl_cmd_type cmd,
   output tesp_pkg::scl_rsp_type      rsp
);
   import tesp_pkg::*;

   localparam int CNT_BITS = $clog2(QUO_BITS > SIZE_BITS ? QUO_BITS : SIZE_BITS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLAMP, ST_DIFF, ST_MUL, ST_ROUND, ST_DIV, ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic        [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic signed [RAW_BITS-1:0]  c_ff, c_in;
   logic signed [RAW_BITS-1:0]  lo_ff, lo_in;
   logic signed [RAW_BITS-1:0]  hi_ff, hi_in;
   logic        [SIZE_BITS-1:0] size_ff, size_in;
   logic        [DIFF_BITS-1:0] den_ff, den_in;
   logic        [DIFF_BITS-1:0] mcand_ff, mcand_in;
   logic        [SIZE_BITS-1:0] mplier_ff, mplier_in;
   logic        [PROD_BITS-1:0] acc_ff, acc_in;
   logic        [DIFF_BITS-1:0] rem_ff, rem_in;
   logic        [QUO_BITS-1:0]  quo_ff, quo_in;

   logic        [PROD_BITS-1:0] num;
   logic        [DIFF_BITS:0]   trial;
   logic        [DIFF_BITS:0]   trial_sub;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      c_in      = c_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      size_in   = size_ff;
      den_in    = den_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;

      num       = acc_ff + PROD_BITS'(den_ff >> 1);
      trial     = {rem_ff, quo_ff[QUO_BITS-1]};
      trial_sub = trial - {1'b0, den_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               c_in     = cmd.raw;
               lo_in    = cmd.lo;
               hi_in    = cmd.hi;
               size_in  = cmd.size;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            // A range with hi <= lo or a size below two gives zero.
            if (size_ff <= SIZE_BITS'(1) || hi_ff <= lo_ff) begin
               quo_in   = '0;
               state_in = ST_DONE;
            end else begin
               if (c_ff < lo_ff) begin
                  c_in = lo_ff;
               end else if (c_ff > hi_ff) begin
                  c_in = hi_ff;
               end
               den_in   = {hi_ff[RAW_BITS-1], hi_ff} - {lo_ff[RAW_BITS-1], lo_ff};
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            mcand_in  = {c_ff[RAW_BITS-1], c_ff} - {lo_ff[RAW_BITS-1], lo_ff};
            mplier_in = size_ff - SIZE_BITS'(1);
            acc_in    = '0;
            cnt_in    = CNT_BITS'(SIZE_BITS - 1);
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            // Multiplier bits enter most significant first.
            acc_in    = {acc_ff[PROD_BITS-2:0], 1'b0}
                      + (mplier_ff[SIZE_BITS-1] ? PROD_BITS'(mcand_ff) : '0);
            mplier_in = {mplier_ff[SIZE_BITS-2:0], 1'b0};
            cnt_in    = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // The quotient is below 2^QUO_BITS, so the upper part of the
            // rounded numerator is already below the divisor.
            rem_in   = num[PROD_BITS-1:QUO_BITS];
            quo_in   = num[QUO_BITS-1:0];
            cnt_in   = CNT_BITS'(QUO_BITS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial_sub[DIFF_BITS]) begin
               rem_in = trial_sub[DIFF_BITS-1:0];
            end else begin
               rem_in = trial[DIFF_BITS-1:0];
            end
            quo_in = {quo_ff[QUO_BITS-2:0], ~trial_sub[DIFF_BITS]};
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      c_ff      <= c_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      size_ff   <= size_in;
      den_ff    <= den_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

   assign rsp.done   = (state_ff == ST_DONE);
   assign rsp.result = quo_ff;

   `TESP_ASSERT_IMP(a_rem_below_den, clock, reset, state_ff == ST_DIV, rem_ff < den_ff, "scaler remainder not below divisor")
   `TESP_ASSERT_IMP(a_start_when_idle, clock, reset, cmd.start, state_ff == ST_IDLE, "scaler started while busy")

endmodule

`default_nettype wire

>>> sv/touch_event_to_screen_point_unit.sv
// An event whose point is not yet valid goes from the idle state to the
// finish state and then into the output register; otherwise each axis,
// X first, passes through the serial scaler (clamp, difference, 13 multiply
// steps, rounding, 13 division steps). One event is in work at a time; the
// shared bit-serial scaler sets the rate. Reset is synchronous: it restores
// the register defaults and clears the stored axes, seen flags and pressed flag.
// ----------------------------------------------------------------------------
// Touch event to screen point unit
// Decodes evdev events into a pressed flag and a scaled, rotated screen point.
// ----------------------------------------------------------------------------
`default_nettype none
`include "touch_event_to_screen_point_unit_macros.svh"

module touch_event_to_screen_point_unit #(
   parameter int COORD_BITS = tesp_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   tesp_req_if.sink                                    req_chan,
   tesp_rsp_if.source                                  rsp_chan,
   input  wire logic                                   csr_write_en,
   input  wire logic [tesp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [tesp_pkg::RAW_BITS-1:0]          csr_wdata
);
   import tesp_pkg::*;

   // Event types and codes of the evdev encoding that this unit reacts to.
   localparam logic [TYPE_BITS-1:0] EV_KEY_TYPE    = TYPE_BITS'(1);
   localparam logic [TYPE_BITS-1:0] EV_ABS_TYPE    = TYPE_BITS'(3);
   localparam logic [CODE_BITS-1:0] CODE_ABS_X     = CODE_BITS'(0);
   localparam logic [CODE_BITS-1:0] CODE_ABS_Y     = CODE_BITS'(1);
   localparam logic [CODE_BITS-1:0] CODE_MT_X      = CODE_BITS'(53);
   localparam logic [CODE_BITS-1:0] CODE_MT_Y      = CODE_BITS'(54);
   localparam logic [CODE_BITS-1:0] CODE_MT_TRACK  = CODE_BITS'(57);
   localparam logic [CODE_BITS-1:0] CODE_BTN_MOUSE = CODE_BITS'(272);
   localparam logic [CODE_BITS-1:0] CODE_BTN_TOUCH = CODE_BITS'(330);

   // Register map.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_MIN    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_MAX    = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_MIN    = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_MAX    = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH    = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT   = CSR_INDEX_BITS'(5);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROTATION = CSR_INDEX_BITS'(6);

   localparam logic [ROT_BITS-1:0] ROT_0   = ROT_BITS'(0);
   localparam logic [ROT_BITS-1:0] ROT_90  = ROT_BITS'(1);
   localparam logic [ROT_BITS-1:0] ROT_180 = ROT_BITS'(2);
   localparam logic [ROT_BITS-1:0] ROT_270 = ROT_BITS'(3);

   // Rotated coordinates range from -1 to 2^SIZE_BITS - 2.
   localparam int ROT_W = SIZE_BITS + 1;
   localparam int TOP_W = 17;
   localparam logic [TOP_W-1:0] COORD_TOP = TOP_W'((1 << COORD_BITS) - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_START_X, ST_WAIT_X, ST_START_Y, ST_WAIT_Y, ST_FINISH
   } state_type;

   // Configuration registers.
   logic signed [RAW_BITS-1:0]  x_min_ff, y_min_ff, x_max_ff, y_max_ff;
   logic        [SIZE_BITS-1:0] width_ff, height_ff;
   logic        [ROT_BITS-1:0]  rotation_ff;

   // Event state.
   state_type                   state_ff, state_in;
   logic signed [RAW_BITS-1:0]  raw_x_ff, raw_x_in;
   logic signed [RAW_BITS-1:0]  raw_y_ff, raw_y_in;
   logic                        seen_x_ff, seen_x_in;
   logic                        seen_y_ff, seen_y_in;
   logic                        touch_ff, touch_in;
   logic        [QUO_BITS-1:0]  px_ff, px_in;
   logic        [QUO_BITS-1:0]  py_ff, py_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_pressed_ff, rsp_pressed_in;
   logic                        rsp_pvalid_ff, rsp_pvalid_in;
   logic        [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic        [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;

   logic                        req_xfer;
   logic                        point_ok;
   logic signed [ROT_W-1:0]     w_m1, h_m1, pxs, pys, rot_x, rot_y;
   scl_cmd_type                 scl_cmd;
   scl_rsp_type                 scl_rsp;

   function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [ROT_W-1:0] v);
      logic [COORD_BITS-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (TOP_W'(v[ROT_W-2:0]) > COORD_TOP) begin
         r = COORD_TOP[COORD_BITS-1:0];
      end else begin
         r = COORD_BITS'(v[ROT_W-2:0]);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration writes: the user must make them only while the unit is idle,
   // which the block does not enforce; scaler and rotation read them directly.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff    <= '0;
         x_max_ff    <= RAW_BITS'(4095);
         y_min_ff    <= '0;
         y_max_ff    <= RAW_BITS'(4095);
         width_ff    <= SIZE_BITS'(800);
         height_ff   <= SIZE_BITS'(480);
         rotation_ff <= ROT_0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_X_MIN:    x_min_ff    <= csr_wdata;
            CSR_X_MAX:    x_max_ff    <= csr_wdata;
            CSR_Y_MIN:    y_min_ff    <= csr_wdata;
            CSR_Y_MAX:    y_max_ff    <= csr_wdata;
            CSR_WIDTH:    width_ff    <= csr_wdata[SIZE_BITS-1:0];
            CSR_HEIGHT:   height_ff   <= csr_wdata[SIZE_BITS-1:0];
            CSR_ROTATION: rotation_ff <= csr_wdata[ROT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Shared bit-serial scaler. X is scaled first, then Y; the scaler
   // latches its operands on the start cycle.
   // ---------------------------------------------------------------------
   always_comb begin
      scl_cmd.start = (state_ff == ST_START_X) || (state_ff == ST_START_Y);
      if (state_ff == ST_START_Y) begin
         scl_cmd.raw  = raw_y_ff;
         scl_cmd.lo   = y_min_ff;
         scl_cmd.hi   = y_max_ff;
         scl_cmd.size = height_ff;
      end else begin
         scl_cmd.raw  = raw_x_ff;
         scl_cmd.lo   = x_min_ff;
         scl_cmd.hi   = x_max_ff;
         scl_cmd.size = width_ff;
      end
   end

   tesp_axis_scaler u_scaler (
      .clock (clock),
      .reset (reset),
      .cmd   (scl_cmd),
      .rsp   (scl_rsp)
   );

   // ---------------------------------------------------------------------
   // Rotation about the panel, with saturation to the coordinate field.
   // A panel size of zero gives -1 here, which saturates to zero.
   // ---------------------------------------------------------------------
   always_comb begin
      w_m1 = signed'({1'b0, width_ff}) - ROT_W'(1);
      h_m1 = signed'({1'b0, height_ff}) - ROT_W'(1);
      pxs  = signed'(ROT_W'(px_ff));
      pys  = signed'(ROT_W'(py_ff));
      unique case (rotation_ff)
         ROT_90: begin
            rot_x = h_m1 - pys;
            rot_y = pxs;
         end
         ROT_180: begin
            rot_x = w_m1 - pxs;
            rot_y = h_m1 - pys;
         end
         ROT_270: begin
            rot_x = pys;
            rot_y = w_m1 - pxs;
         end
         default: begin
            rot_x = pxs;
            rot_y = pys;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Event decode and sequencing.
   // ---------------------------------------------------------------------
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign point_ok = seen_x_ff && seen_y_ff;

   always_comb begin
      state_in       = state_ff;
      raw_x_in       = raw_x_ff;
      raw_y_in       = raw_y_ff;
      seen_x_in      = seen_x_ff;
      seen_y_in      = seen_y_ff;
      touch_in       = touch_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_pvalid_in  = rsp_pvalid_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;

      // The output register empties on a transfer and may refill below.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.event_type == EV_ABS_TYPE) begin
                  if (req_chan.event_code == CODE_ABS_X ||
                      req_chan.event_code == CODE_MT_X) begin
                     raw_x_in  = req_chan.event_value;
                     seen_x_in = 1'b1;
                  end else if (req_chan.event_code == CODE_ABS_Y ||
                               req_chan.event_code == CODE_MT_Y) begin
                     raw_y_in  = req_chan.event_value;
                     seen_y_in = 1'b1;
                  end else if (req_chan.event_code == CODE_MT_TRACK) begin
                     // A negative tracking id marks the contact as lifted.
                     touch_in = ~req_chan.event_value[RAW_BITS-1];
                  end
               end else if (req_chan.event_type == EV_KEY_TYPE) begin
                  if (req_chan.event_code == CODE_BTN_TOUCH ||
                      req_chan.event_code == CODE_BTN_MOUSE) begin
                     touch_in = (req_chan.event_value != '0);
                  end
               end
               state_in = (seen_x_in && seen_y_in) ? ST_START_X : ST_FINISH;
            end
         end
         ST_START_X: begin
            state_in = ST_WAIT_X;
         end
         ST_WAIT_X: begin
            if (scl_rsp.done) begin
               px_in    = scl_rsp.result;
               state_in = ST_START_Y;
            end
         end
         ST_START_Y: begin
            state_in = ST_WAIT_Y;
         end
         ST_WAIT_Y: begin
            if (scl_rsp.done) begin
               py_in    = scl_rsp.result;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Wait here only while a previous result is still not taken.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pressed_in = touch_ff;
               rsp_pvalid_in  = point_ok;
               rsp_x_in       = point_ok ? sat_coord(rot_x) : '0;
               rsp_y_in       = point_ok ? sat_coord(rot_y) : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         raw_x_ff     <= '0;
         raw_y_ff     <= '0;
         seen_x_ff    <= 1'b0;
         seen_y_ff    <= 1'b0;
         touch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         raw_x_ff     <= raw_x_in;
         raw_y_ff     <= raw_y_in;
         seen_x_ff    <= seen_x_in;
         seen_y_ff    <= seen_y_in;
         touch_ff     <= touch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff          <= px_in;
      py_ff          <= py_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_pvalid_ff  <= rsp_pvalid_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pressed     = rsp_pressed_ff;
   assign rsp_chan.point_valid = rsp_pvalid_ff;
   assign rsp_chan.point_x     = rsp_x_ff;
   assign rsp_chan.point_y     = rsp_y_ff;

   `TESP_ASSERT_IMP(a_done_while_waiting, clock, reset, scl_rsp.done, state_ff == ST_WAIT_X || state_ff == ST_WAIT_Y, "scaler finished outside a wait state")
   `TESP_ASSERT_IMP(a_invalid_point_zero, clock, reset, rsp_valid_ff && !rsp_pvalid_ff, rsp_x_ff == '0 && rsp_y_ff == '0, "point not zero before both axes are seen")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Touch event to screen point unit: self-checking testbench
// Feeds evdev style events into the unit and checks each screen point that
// comes back against a predictor kept in step with the unit's registers.
// A short directed part covers the event kinds and the corner cases of the
// scaling. Random touch gestures then run under a series of register
// settings, with idle bursts on both channels and two long stalls of the
// receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int COORD_W = tesp_pkg::COORD_BITS_DEFAULT;
   localparam int TYPE_W  = tesp_pkg::TYPE_BITS;
   localparam int CODE_W  = tesp_pkg::CODE_BITS;
   localparam int RAW_W   = tesp_pkg::RAW_BITS;
   localparam int SIZE_W  = tesp_pkg::SIZE_BITS;

   // Event types and codes that the unit decodes.
   localparam logic [TYPE_W-1:0] EV_SYN = 0;
   localparam logic [TYPE_W-1:0] EV_KEY = 1;
   localparam logic [TYPE_W-1:0] EV_REL = 2;
   localparam logic [TYPE_W-1:0] EV_ABS = 3;
   localparam logic [TYPE_W-1:0] EV_TYPE_TOP = '1;

   localparam logic [CODE_W-1:0] SYN_REPORT     = 0;
   localparam logic [CODE_W-1:0] ABS_X          = 0;
   localparam logic [CODE_W-1:0] ABS_Y          = 1;
   localparam logic [CODE_W-1:0] MT_POS_X       = 53;
   localparam logic [CODE_W-1:0] MT_POS_Y       = 54;
   localparam logic [CODE_W-1:0] MT_TRACKING_ID = 57;
   localparam logic [CODE_W-1:0] BTN_MOUSE      = 272;
   localparam logic [CODE_W-1:0] BTN_TOUCH      = 330;
   localparam logic [CODE_W-1:0] EV_CODE_TOP    = '1;

   localparam logic [RAW_W-1:0] RAW_MOST_NEG = 32'h8000_0000;
   localparam logic [RAW_W-1:0] RAW_MOST_POS = 32'h7FFF_FFFF;
   localparam logic [RAW_W-1:0] RAW_MINUS_1  = 32'hFFFF_FFFF;

   typedef enum logic [tesp_pkg::CSR_INDEX_BITS-1:0] {
      REG_X_MIN,
      REG_X_MAX,
      REG_Y_MIN,
      REG_Y_MAX,
      REG_WIDTH,
      REG_HEIGHT,
      REG_ROTATION
   } csr_reg_e;

   typedef enum logic [tesp_pkg::ROT_BITS-1:0] {
      ROT_0,
      ROT_90,
      ROT_180,
      ROT_270
   } rotation_e;

   // Run shape. The worst quiet spell in a correct run is the long receiver
   // stall plus one event in work plus idle bursts; the watchdog allows several
   // times that.
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_EVENTS  = 172;
   localparam int LONG_STALL    = 400;
   localparam int DRAIN_CYCLES  = 80;
   localparam int STALL_LIMIT   = 4000;
   localparam int PRINT_LIMIT   = 40;

   typedef struct packed {
      logic [TYPE_W-1:0] ev_type;
      logic [CODE_W-1:0] ev_code;
      logic [RAW_W-1:0]  ev_value;
   } touch_event_t;

   typedef struct packed {
      logic               pressed;
      logic               point_valid;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
   } screen_point_t;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_en;
   logic [tesp_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [RAW_W-1:0]  csr_wdata;

   tesp_req_if                         req_if ();
   tesp_rsp_if #(.COORD_BITS(COORD_W)) rsp_if ();

   touch_event_to_screen_point_unit #(
      .COORD_BITS(COORD_W)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: a shadow of the registers and of the unit's memory of
   // the last raw coordinates, the seen flags and the pressed flag.
   // ------------------------------------------------------------------------
   logic signed [RAW_W-1:0] cfg_x_lo, cfg_x_hi, cfg_y_lo, cfg_y_hi;
   logic [SIZE_W-1:0]       cfg_width, cfg_height;
   rotation_e               cfg_rotation;

   logic signed [RAW_W-1:0] last_raw_x, last_raw_y;
   logic                    have_x, have_y, pen_down;

   touch_event_t  pending_events[$];
   screen_point_t expected_points[$];

   int  mismatch_count = 0;
   int  stall_cycles   = 0;
   int  tx_gap_left    = 0;
   int  rx_gap_left    = 0;
   int  stall_left     = 0;
   int  stalls_served  = 0;
   int  stalls_armed   = 0;
   int  events_queued  = 0;
   logic quiet_tail    = 1'b0;
   logic req_taken     = 1'b0;

   // Clamp the raw value into [lo, hi] and scale it onto 0 .. size-1 with
   // round-to-nearest division; hi <= lo or a size below 2 gives 0.
   function automatic longint scale_axis_to_panel(input logic signed [RAW_W-1:0] raw,
                                                  input logic signed [RAW_W-1:0] lo,
                                                  input logic signed [RAW_W-1:0] hi,
                                                  input logic [SIZE_W-1:0] size);
      longint c;
      longint span;
      if (size <= 1 || hi <= lo) return 0;
      c = raw;
      if (c < lo) c = lo;
      if (c > hi) c = hi;
      span = longint'(hi) - longint'(lo);
      return ((c - longint'(lo)) * (longint'(size) - 1) + span / 2) / span;
   endfunction

   // Saturate a rotated coordinate into the output field.
   function automatic logic [COORD_W-1:0] clip_coord(input longint v);
      if (v < 0) return '0;
      if (v > longint'((1 << COORD_W) - 1)) return '1;
      return v[COORD_W-1:0];
   endfunction

   // Apply one accepted event to the predictor and return the point the unit
   // must report for it.
   function automatic screen_point_t predict_screen_point(input touch_event_t ev);
      screen_point_t pt;
      longint px, py, w, h, rx, ry;
      if (ev.ev_type == EV_ABS) begin
         if (ev.ev_code == ABS_X || ev.ev_code == MT_POS_X) begin
            last_raw_x = ev.ev_value;
            have_x     = 1'b1;
         end else if (ev.ev_code == ABS_Y || ev.ev_code == MT_POS_Y) begin
            last_raw_y = ev.ev_value;
            have_y     = 1'b1;
         end else if (ev.ev_code == MT_TRACKING_ID) begin
            pen_down = ($signed(ev.ev_value) >= 0);
         end
      end else if (ev.ev_type == EV_KEY) begin
         if (ev.ev_code == BTN_TOUCH || ev.ev_code == BTN_MOUSE)
            pen_down = (ev.ev_value != 0);
      end
      pt             = '0;
      pt.pressed     = pen_down;
      pt.point_valid = have_x && have_y;
      if (pt.point_valid) begin
         px = scale_axis_to_panel(last_raw_x, cfg_x_lo, cfg_x_hi, cfg_width);
         py = scale_axis_to_panel(last_raw_y, cfg_y_lo, cfg_y_hi, cfg_height);
         w  = longint'(cfg_width);
         h  = longint'(cfg_height);
         case (cfg_rotation)
            ROT_90: begin
               rx = h - 1 - py;
               ry = px;
            end
            ROT_180: begin
               rx = w - 1 - px;
               ry = h - 1 - py;
            end
            ROT_270: begin
               rx = py;
               ry = w - 1 - px;
            end
            default: begin
               rx = px;
               ry = py;
            end
         endcase
         pt.point_x = clip_coord(rx);
         pt.point_y = clip_coord(ry);
      end
      return pt;
   endfunction

   // ------------------------------------------------------------------------
   // Mismatch reporting. Printing is capped so that a badly broken unit does
   // not flood the log, but every mismatch is counted.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input longint got, input longint want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
   endtask

   // ------------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. A result transfer
   // retires the oldest expectation before an event transfer in the same
   // edge adds a new one, since the result always belongs to an older event.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      screen_point_t want;
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("screen point transfer with no event outstanding");
            end else begin
               want = expected_points.pop_front();
               check_field("pressed", rsp_if.pressed, want.pressed);
               check_field("point_valid", rsp_if.point_valid, want.point_valid);
               check_field("point_x", rsp_if.point_x, want.point_x);
               check_field("point_y", rsp_if.point_y, want.point_y);
            end
         end
         if (req_if.valid && req_if.ready)
            expected_points.push_back(predict_screen_point(
               '{req_if.event_type, req_if.event_code, req_if.event_value}));
      end
   end

   // Watchdog: a long spell with no transfer on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("touch_event_to_screen_point_unit verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Event driver: presents the next pending event at the falling edge once
   // the previous one has been transferred. Valid is held until the transfer,
   // and idle bursts are slipped in between events.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_events
      touch_event_t ev;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (tx_gap_left != 0) begin
            tx_gap_left  <= tx_gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            tx_gap_left  <= $urandom_range(0, 5);
            req_if.valid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            ev                 = pending_events.pop_front();
            req_if.valid       <= 1'b1;
            req_if.event_type  <= ev.ev_type;
            req_if.event_code  <= ev.ev_code;
            req_if.event_value <= ev.ev_value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Long receiver stall, counted in its own process. Each time the stimulus
   // arms it, ready stays low until a counter loaded from LONG_STALL runs out,
   // so that the unit holds its result and pushes back on the event channel.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stalls_served != stalls_armed) begin
         stall_left    <= LONG_STALL;
         stalls_served <= stalls_armed;
      end
   end

   // Result receiver: ready with random idle bursts, none in the quiet tail.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
      end else if (rx_gap_left != 0) begin
         rx_gap_left  <= rx_gap_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         rx_gap_left  <= $urandom_range(0, 5);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   task automatic queue_event(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
                              input logic [RAW_W-1:0] v);
      pending_events.push_back('{t, c, v});
      if (t == EV_ABS || t == EV_KEY) events_queued++;
   endtask

   // Register writes happen only while the unit is idle, so the shadow copy
   // can be updated straight away.
   task automatic write_csr(input csr_reg_e idx, input logic [RAW_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_X_MIN:  cfg_x_lo     = data;
         REG_X_MAX:  cfg_x_hi     = data;
         REG_Y_MIN:  cfg_y_lo     = data;
         REG_Y_MAX:  cfg_y_hi     = data;
         REG_WIDTH:  cfg_width    = data[SIZE_W-1:0];
         REG_HEIGHT: cfg_height   = data[SIZE_W-1:0];
         default:    cfg_rotation = rotation_e'(data[tesp_pkg::ROT_BITS-1:0]);
      endcase
   endtask

   task automatic load_setting(input logic [RAW_W-1:0] x_lo, input logic [RAW_W-1:0] x_hi,
                               input logic [RAW_W-1:0] y_lo, input logic [RAW_W-1:0] y_hi,
                               input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                               input rotation_e rot);
      write_csr(REG_X_MIN, x_lo);
      write_csr(REG_X_MAX, x_hi);
      write_csr(REG_Y_MIN, y_lo);
      write_csr(REG_Y_MAX, y_hi);
      write_csr(REG_WIDTH, RAW_W'(w));
      write_csr(REG_HEIGHT, RAW_W'(h));
      write_csr(REG_ROTATION, RAW_W'(rot));
   endtask

   // The sender pauses here until every event has been transferred and every
   // screen point has come back.
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (pending_events.size() != 0 || req_if.valid || expected_points.size() != 0);
   endtask

   // Raw coordinate for the current range: mostly inside it, with the bounds
   // themselves, values just outside and arbitrary values mixed in.
   function automatic logic [RAW_W-1:0] pick_raw(input logic signed [RAW_W-1:0] lo,
                                                 input logic signed [RAW_W-1:0] hi);
      longint span;
      span = longint'(hi) - longint'(lo);
      case ($urandom_range(0, 9))
         0: return lo;
         1: return hi;
         2: return $urandom;
         3: return lo - RAW_W'($urandom_range(1, 500));
         4: return hi + RAW_W'($urandom_range(1, 500));
         default: begin
            if (span <= 0) return $urandom;
            return RAW_W'(longint'(lo) + longint'($urandom) % (span + 1));
         end
      endcase
   endfunction

   task automatic pick_range(output logic [RAW_W-1:0] lo, output logic [RAW_W-1:0] hi);
      case ($urandom_range(0, 9))
         0: begin
            lo = RAW_MOST_NEG;
            hi = RAW_MOST_POS;
         end
         1: begin
            // Empty or single-point range.
            lo = $urandom;
            hi = lo - RAW_W'($urandom_range(0, 1000));
         end
         2: begin
            lo = $urandom;
            hi = $urandom;
         end
         default: begin
            lo = RAW_W'($urandom_range(0, 6000)) - RAW_W'(3000);
            hi = lo + RAW_W'($urandom_range(1, 70000));
         end
      endcase
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0: return SIZE_W'(1);
         1: return SIZE_W'(2);
         2: return SIZE_W'(4096);
         default: return SIZE_W'($urandom_range(3, 4095));
      endcase
   endfunction

   // One gesture: contact, a few moves each closed by a sync report, then a
   // release. Multi-touch gestures use the tracking id and the MT axes,
   // single-touch ones the plain axes, mouse ones the mouse button. Now and
   // then the release is left out, as a broken sequence.
   task automatic queue_touch_frame();
      int style;
      logic [CODE_W-1:0] x_code, y_code, button;
      style  = $urandom_range(0, 2);
      x_code = (style == 0) ? MT_POS_X : ABS_X;
      y_code = (style == 0) ? MT_POS_Y : ABS_Y;
      button = (style == 2) ? BTN_MOUSE : BTN_TOUCH;
      if (style == 0)
         queue_event(EV_ABS, MT_TRACKING_ID, ($urandom_range(0, 1) == 0) ?
                     RAW_W'($urandom_range(0, 1000)) : ($urandom & RAW_MOST_POS));
      queue_event(EV_ABS, x_code, pick_raw(cfg_x_lo, cfg_x_hi));
      queue_event(EV_ABS, y_code, pick_raw(cfg_y_lo, cfg_y_hi));
      queue_event(EV_KEY, button, ($urandom_range(0, 3) == 0) ? ($urandom | 32'd1) : 32'd1);
      queue_event(EV_SYN, SYN_REPORT, '0);
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(0, 2) != 1) queue_event(EV_ABS, x_code, pick_raw(cfg_x_lo, cfg_x_hi));
         if ($urandom_range(0, 2) != 0) queue_event(EV_ABS, y_code, pick_raw(cfg_y_lo, cfg_y_hi));
         queue_event(EV_SYN, SYN_REPORT, '0);
      end
      if ($urandom_range(0, 7) != 0) begin
         if (style == 0)
            queue_event(EV_ABS, MT_TRACKING_ID, ($urandom_range(0, 1) == 0) ?
                        RAW_MINUS_1 : ($urandom | RAW_MOST_NEG));
         queue_event(EV_KEY, button, '0);
         queue_event(EV_SYN, SYN_REPORT, '0);
      end
   endtask

   // Noise: arbitrary events, most of which the unit should ignore.
   task automatic queue_noise();
      case ($urandom_range(0, 2))
         0:       queue_event(TYPE_W'($urandom), CODE_W'($urandom), $urandom);
         1:       queue_event(EV_ABS, CODE_W'($urandom), $urandom);
         default: queue_event(EV_KEY, CODE_W'($urandom), $urandom);
      endcase
   endtask

   task automatic queue_random_events(input int target);
      int start;
      start = events_queued;
      while (events_queued - start < target) begin
         if ($urandom_range(0, 9) != 0) queue_touch_frame();
         else queue_noise();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [RAW_W-1:0] x_lo, x_hi, y_lo, y_hi;

      // Every input of the unit is known from time zero.
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = REG_X_MIN;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.event_type  = '0;
      req_if.event_code  = '0;
      req_if.event_value = '0;
      rsp_if.ready       = 1'b0;

      // Shadow registers and state as the unit comes out of reset.
      cfg_x_lo     = 0;
      cfg_x_hi     = 4095;
      cfg_y_lo     = 0;
      cfg_y_hi     = 4095;
      cfg_width    = 800;
      cfg_height   = 480;
      cfg_rotation = ROT_0;
      last_raw_x   = '0;
      last_raw_y   = '0;
      have_x       = 1'b0;
      have_y       = 1'b0;
      pen_down     = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset settings. The point stays invalid until
      // both axes have been seen; the pressed flag follows the tracking id
      // sign and the touch and mouse buttons; other events change nothing.
      queue_event(EV_SYN, SYN_REPORT, '0);
      queue_event(EV_ABS, ABS_X, 32'd100);
      queue_event(EV_KEY, BTN_TOUCH, 32'd1);
      queue_event(EV_ABS, ABS_Y, 32'd200);
      queue_event(EV_ABS, MT_POS_X, 32'd4095);
      queue_event(EV_ABS, MT_POS_Y, '0);
      queue_event(EV_ABS, MT_POS_X, RAW_MOST_NEG);
      queue_event(EV_ABS, MT_POS_Y, RAW_MOST_POS);
      queue_event(EV_ABS, MT_TRACKING_ID, RAW_MINUS_1);
      queue_event(EV_ABS, MT_TRACKING_ID, '0);
      queue_event(EV_KEY, BTN_TOUCH, '0);
      queue_event(EV_KEY, BTN_MOUSE, RAW_MINUS_1);
      queue_event(EV_KEY, BTN_MOUSE, '0);
      queue_event(EV_ABS, MT_TRACKING_ID, RAW_MOST_POS);
      queue_event(EV_ABS, MT_TRACKING_ID, RAW_MOST_NEG);
      queue_event(EV_TYPE_TOP, EV_CODE_TOP, RAW_MINUS_1);
      queue_event(EV_ABS, EV_CODE_TOP, 32'd5);
      queue_event(EV_KEY, ABS_X, 32'd1);
      queue_event(EV_REL, ABS_X, 32'd7);
      queue_event(EV_ABS, ABS_Y, 32'd2048);
      wait_until_drained();

      // Widest raw ranges and a 4096 by 4096 panel, turned half a revolution.
      load_setting(RAW_MOST_NEG, RAW_MOST_POS, RAW_MOST_NEG, RAW_MOST_POS,
                   SIZE_W'(4096), SIZE_W'(4096), ROT_180);
      queue_event(EV_ABS, MT_POS_X, RAW_MOST_NEG);
      queue_event(EV_ABS, MT_POS_Y, RAW_MOST_POS);
      queue_event(EV_ABS, MT_POS_X, '0);
      queue_event(EV_ABS, MT_POS_Y, RAW_MINUS_1);
      wait_until_drained();

      // A single-point X range, an inverted Y range and a one-pixel width.
      load_setting(32'd77, 32'd77, 32'd10, 32'd5, SIZE_W'(1), SIZE_W'(4096), ROT_90);
      queue_event(EV_ABS, ABS_X, 32'd77);
      queue_event(EV_ABS, ABS_Y, 32'd7);
      wait_until_drained();

      // A one-pixel height with a quarter turn the other way.
      load_setting('0, 32'd4095, '0, 32'd4095, SIZE_W'(4096), SIZE_W'(1), ROT_270);
      queue_event(EV_ABS, ABS_X, 32'd4095);
      queue_event(EV_ABS, ABS_Y, '0);
      wait_until_drained();

      // Random part: a fresh setting per phase, every rotation in turn. The
      // first and the sixth phase also hold off the receiver for a long
      // stretch while the driver keeps offering events. The last phase runs
      // with no idling at all.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_range(x_lo, x_hi);
         pick_range(y_lo, y_hi);
         load_setting(x_lo, x_hi, y_lo, y_hi, pick_size(), pick_size(),
                      rotation_e'(phase % 4));
         if (phase == 0 || phase == 5) stalls_armed <= stalls_armed + 1;
         if (phase == RANDOM_PHASES - 1) quiet_tail <= 1'b1;
         queue_random_events(PHASE_EVENTS);
         wait_until_drained();
      end

      // Let anything stray come out before the verdict.
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_points.size() != 0)
         report_mismatch($sformatf("%0d screen points never arrived", expected_points.size()));

      if (mismatch_count == 0) begin
         $display("touch_event_to_screen_point_unit verification clean");
      end else begin
         $display("touch_event_to_screen_point_unit verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/tesp_pkg.sv
sv/tesp_channels.sv
sv/tesp_axis_scaler.sv
sv/touch_event_to_screen_point_unit.sv
tb/sv/tb_top.sv
